// File: design/pcn_pkg.sv
`timescale 1ns / 1ps
package pcn_pkg;
  localparam int unsigned ColumnDepth = 64;
  localparam int unsigned AddrW = $clog2(ColumnDepth);
  localparam int unsigned CountW = $clog2(ColumnDepth + 1);
  localparam int unsigned ValueW = 16;
  localparam int unsigned IndexW = 6;
  localparam int unsigned SumW = 20;
  localparam int unsigned RunW = 23;
  localparam int unsigned DivW = 32;
  localparam int unsigned DenW = RunW;
  localparam int unsigned CfgW = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OneQ15 = 32768;
  localparam int unsigned NormTol = 3;
  localparam int unsigned TotalReset = 32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VIRTUAL = 2'd0,
    CFG_TOTAL   = 2'd1,
    CFG_MIN     = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_MISS_WR,
    OP_FILL_DIV,
    OP_FILL_WR,
    OP_SCALE_MUL,
    OP_SCALE_DIV,
    OP_SCALE_WR,
    OP_VIRT_WR,
    OP_OUT_LD
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [AddrW-1:0] addr;
    logic             store;
    logic             first;
    logic [AddrW-1:0] den;
  } dp_cmd_t;

  typedef struct packed {
    logic [IndexW-1:0] idx;
    logic              virt;
    logic              sum_low;
    logic              fill_en;
    logic              scale_need;
    logic              div_done;
  } dp_status_t;
endpackage

// File: design/pcn_in_if.sv
`timescale 1ns / 1ps
interface pcn_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcn_pkg::ValueW-1:0]    value_in;
  logic [pcn_pkg::IndexW-1:0]    loop_index;
  logic [pcn_pkg::SumW-1:0]      added_sum;
  logic                          virtual_used;
  logic                          last_element;
  modport source (output valid, value_in, loop_index, added_sum, virtual_used, last_element,
                  input ready);
  modport sink (input valid, value_in, loop_index, added_sum, virtual_used, last_element,
                output ready);
endinterface

// File: design/pcn_out_if.sv
`timescale 1ns / 1ps
interface pcn_out_if;
  logic                       valid;
  logic                       ready;
  logic [pcn_pkg::ValueW-1:0] value_out;
  logic                       last_out;
  modport source (output valid, value_out, last_out, input ready);
  modport sink (input valid, value_out, last_out, output ready);
endinterface

// File: design/pcn_ram.sv
`timescale 1ns / 1ps
module pcn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/pcn_divider.sv
`timescale 1ns / 1ps
module pcn_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pcn_pkg::DivW-1:0] num_i,
  input  logic [pcn_pkg::DenW-1:0] den_i,
  output logic                     done_o,
  output logic [pcn_pkg::DivW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(pcn_pkg::DivW);

  logic                      busy_q, done_q;
  logic [CntW-1:0]           cnt_q;
  logic [pcn_pkg::DenW-1:0]  rem_q, den_q;
  logic [pcn_pkg::DivW-1:0]  quo_q;
  logic [pcn_pkg::DenW:0]    shifted, diff;

  assign shifted = {rem_q, quo_q[pcn_pkg::DivW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(pcn_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      if (!diff[pcn_pkg::DenW]) begin
        rem_q <= diff[pcn_pkg::DenW-1:0];
        quo_q <= {quo_q[pcn_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[pcn_pkg::DenW-1:0];
        quo_q <= {quo_q[pcn_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: design/pcn_datapath.sv
`timescale 1ns / 1ps
module pcn_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pcn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pcn_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [pcn_pkg::ValueW-1:0]  value_in_i,
  input  logic [pcn_pkg::IndexW-1:0]  loop_index_i,
  input  logic [pcn_pkg::SumW-1:0]    added_sum_i,
  input  logic                        virtual_used_i,
  input  pcn_pkg::dp_cmd_t            cmd_i,
  output pcn_pkg::dp_status_t         status_o,
  output logic [pcn_pkg::ValueW-1:0]  value_out_o
);
  localparam int unsigned BaseW = pcn_pkg::SumW + 2;
  localparam int unsigned WideW = pcn_pkg::RunW + 1;

  logic [pcn_pkg::ValueW-1:0] vp_q, min_q, out_q, rdata;
  logic [pcn_pkg::SumW-1:0]   total_q;
  logic [pcn_pkg::IndexW-1:0] idx_q;
  logic                       virt_q;
  logic [pcn_pkg::RunW-1:0]   sum_q, sum_d;
  logic [pcn_pkg::DivW-1:0]   prod_q, quo, div_num;
  logic [pcn_pkg::DenW-1:0]   div_den;
  logic                       div_start, div_done;

  logic signed [BaseW-1:0]    base_s;
  logic signed [WideW-1:0]    sum_s, delta_s;
  logic [WideW-1:0]           miss_wide;
  logic [pcn_pkg::ValueW-1:0] miss_val, vp_used, m_val, scaled;
  logic signed [pcn_pkg::ValueW+1:0] m_wide;
  logic [WideW-1:0]           sum_u, m_u;
  logic                       we;
  logic [pcn_pkg::AddrW-1:0]  waddr;
  logic [pcn_pkg::ValueW-1:0] wdata;

  assign base_s  = signed'(BaseW'(total_q)) - signed'(BaseW'(vp_q));
  assign sum_s   = signed'({1'b0, sum_q});
  assign delta_s = WideW'(base_s) - sum_s;
  assign miss_wide = WideW'(rdata) + WideW'(delta_s);
  assign miss_val  = (miss_wide > WideW'({pcn_pkg::ValueW{1'b1}})) ? '1
                                                                    : miss_wide[pcn_pkg::ValueW-1:0];

  assign vp_used = virt_q ? vp_q : '0;
  assign m_wide  = signed'((pcn_pkg::ValueW+2)'(pcn_pkg::OneQ15))
                 - signed'((pcn_pkg::ValueW+2)'(vp_used));
  assign m_val   = m_wide[pcn_pkg::ValueW+1] ? '0 : m_wide[pcn_pkg::ValueW-1:0];
  assign sum_u   = WideW'(sum_q);
  assign m_u     = WideW'(m_val);

  always_comb begin
    scaled = '0;
    if (sum_q != '0) begin
      scaled = (quo > pcn_pkg::DivW'({pcn_pkg::ValueW{1'b1}})) ? '1
                                                                 : quo[pcn_pkg::ValueW-1:0];
    end
    if (scaled < min_q) begin
      scaled = '0;
    end
  end

  assign div_start = (cmd_i.op == pcn_pkg::OP_FILL_DIV) || (cmd_i.op == pcn_pkg::OP_SCALE_DIV);
  assign div_num   = (cmd_i.op == pcn_pkg::OP_FILL_DIV)
                   ? pcn_pkg::DivW'(pcn_pkg::SumW'(pcn_pkg::OneQ15) - total_q) : prod_q;
  assign div_den   = (cmd_i.op == pcn_pkg::OP_FILL_DIV) ? pcn_pkg::DenW'(cmd_i.den) : sum_q;

  pcn_divider u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.addr;
    wdata = rdata;
    sum_d = sum_q;
    case (cmd_i.op)
      pcn_pkg::OP_LOAD: begin
        we    = cmd_i.store;
        wdata = value_in_i;
        if (cmd_i.first) begin
          sum_d = pcn_pkg::RunW'(added_sum_i);
        end
      end
      pcn_pkg::OP_MISS_WR: begin
        we    = 1'b1;
        wdata = miss_val;
        sum_d = pcn_pkg::RunW'(base_s);
      end
      pcn_pkg::OP_FILL_WR: begin
        if (rdata == '0) begin
          we    = 1'b1;
          wdata = quo[pcn_pkg::ValueW-1:0];
          sum_d = sum_q + pcn_pkg::RunW'(quo[pcn_pkg::ValueW-1:0]);
        end
      end
      pcn_pkg::OP_SCALE_WR: begin
        we    = 1'b1;
        wdata = scaled;
      end
      pcn_pkg::OP_VIRT_WR: begin
        we    = 1'b1;
        wdata = vp_q;
      end
      default: begin
      end
    endcase
  end

  pcn_ram #(
    .Width (pcn_pkg::ValueW),
    .Depth (pcn_pkg::ColumnDepth)
  ) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q    <= '0;
      total_q <= pcn_pkg::SumW'(pcn_pkg::TotalReset);
      min_q   <= '0;
      idx_q   <= '0;
      virt_q  <= 1'b0;
      sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pcn_pkg::CFG_VIRTUAL: vp_q    <= cfg_data_i[pcn_pkg::ValueW-1:0];
          pcn_pkg::CFG_TOTAL:   total_q <= cfg_data_i[pcn_pkg::SumW-1:0];
          pcn_pkg::CFG_MIN:     min_q   <= cfg_data_i[pcn_pkg::ValueW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == pcn_pkg::OP_LOAD && cmd_i.first) begin
        idx_q  <= loop_index_i;
        virt_q <= virtual_used_i;
      end
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pcn_pkg::OP_SCALE_MUL) begin
      prod_q <= pcn_pkg::DivW'(rdata) * pcn_pkg::DivW'(m_val);
    end
    if (cmd_i.op == pcn_pkg::OP_OUT_LD) begin
      out_q <= rdata;
    end
  end

  assign status_o.idx        = idx_q;
  assign status_o.virt       = virt_q;
  assign status_o.sum_low    = sum_s < WideW'(base_s);
  assign status_o.fill_en    = total_q < pcn_pkg::SumW'(pcn_pkg::OneQ15);
  assign status_o.scale_need = (sum_u + WideW'(pcn_pkg::NormTol) < m_u)
                            || (sum_u > m_u + WideW'(pcn_pkg::NormTol));
  assign status_o.div_done   = div_done;
  assign value_out_o         = out_q;
endmodule

// File: design/pcn_controller.sv
`timescale 1ns / 1ps
module pcn_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output logic                out_last_o,
  input  logic                out_ready_i,
  input  pcn_pkg::dp_status_t status_i,
  output pcn_pkg::dp_cmd_t    cmd_o
);
  typedef enum logic [4:0] {
    ST_LOAD, ST_MISS_RD, ST_MISS_WR, ST_FILL_DIV, ST_FILL_WAIT, ST_FILL_RD, ST_FILL_WR,
    ST_SCALE_CHK, ST_SCALE_RD, ST_SCALE_MUL, ST_SCALE_DIV, ST_SCALE_WAIT, ST_SCALE_WR,
    ST_VIRT, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
  } state_e;

  localparam int unsigned CmpW = pcn_pkg::IndexW + 1;

  state_e                     state_q, state_d;
  logic [pcn_pkg::CountW-1:0] count_q, count_d, n_q, n_d, j_q, j_d, start;
  logic                       valid_q, valid_d, last_q, last_d;
  logic                       idx_ok, at_end, j_last;

  assign start  = status_i.virt ? pcn_pkg::CountW'(1) : '0;
  assign idx_ok = CmpW'(status_i.idx) < CmpW'(n_q);
  assign at_end = j_q >= n_q;
  assign j_last = (j_q + 1'b1) == n_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    j_d       = j_q;
    valid_d   = valid_q;
    last_d    = last_q;
    cmd_o     = '0;
    cmd_o.op  = pcn_pkg::OP_NONE;
    cmd_o.addr = j_q[pcn_pkg::AddrW-1:0];
    cmd_o.den  = pcn_pkg::AddrW'(n_q - 1'b1);
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op    = pcn_pkg::OP_LOAD;
          cmd_o.addr  = count_q[pcn_pkg::AddrW-1:0];
          cmd_o.first = count_q == '0;
          cmd_o.store = count_q < pcn_pkg::CountW'(pcn_pkg::ColumnDepth);
          if (cmd_o.store) begin
            count_d = count_q + 1'b1;
          end
          if (in_last_i) begin
            n_d     = count_d;
            state_d = ST_MISS_RD;
          end
        end
      end
      ST_MISS_RD: begin
        cmd_o.addr = status_i.idx[pcn_pkg::AddrW-1:0];
        if (status_i.sum_low && idx_ok) begin
          cmd_o.op = pcn_pkg::OP_READ;
          state_d  = ST_MISS_WR;
        end else begin
          state_d = ST_FILL_DIV;
        end
      end
      ST_MISS_WR: begin
        cmd_o.addr = status_i.idx[pcn_pkg::AddrW-1:0];
        cmd_o.op   = pcn_pkg::OP_MISS_WR;
        state_d    = ST_FILL_DIV;
      end
      ST_FILL_DIV: begin
        j_d = start;
        if (status_i.fill_en && n_q > pcn_pkg::CountW'(1)) begin
          cmd_o.op = pcn_pkg::OP_FILL_DIV;
          state_d  = ST_FILL_WAIT;
        end else begin
          state_d = ST_SCALE_CHK;
        end
      end
      ST_FILL_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_FILL_RD;
        end
      end
      ST_FILL_RD: begin
        if (at_end) begin
          state_d = ST_SCALE_CHK;
        end else begin
          cmd_o.op = pcn_pkg::OP_READ;
          state_d  = ST_FILL_WR;
        end
      end
      ST_FILL_WR: begin
        cmd_o.op = pcn_pkg::OP_FILL_WR;
        j_d      = j_q + 1'b1;
        state_d  = ST_FILL_RD;
      end
      ST_SCALE_CHK: begin
        j_d     = start;
        state_d = status_i.scale_need ? ST_SCALE_RD : ST_VIRT;
      end
      ST_SCALE_RD: begin
        if (at_end) begin
          state_d = ST_VIRT;
        end else begin
          cmd_o.op = pcn_pkg::OP_READ;
          state_d  = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: begin
        cmd_o.op = pcn_pkg::OP_SCALE_MUL;
        state_d  = ST_SCALE_DIV;
      end
      ST_SCALE_DIV: begin
        cmd_o.op = pcn_pkg::OP_SCALE_DIV;
        state_d  = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_SCALE_WR;
        end
      end
      ST_SCALE_WR: begin
        cmd_o.op = pcn_pkg::OP_SCALE_WR;
        j_d      = j_q + 1'b1;
        state_d  = ST_SCALE_RD;
      end
      ST_VIRT: begin
        cmd_o.addr = '0;
        if (status_i.virt) begin
          cmd_o.op = pcn_pkg::OP_VIRT_WR;
        end
        j_d     = '0;
        state_d = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        cmd_o.op = pcn_pkg::OP_READ;
        state_d  = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.op = pcn_pkg::OP_OUT_LD;
        valid_d  = 1'b1;
        last_d   = j_last;
        state_d  = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          if (last_q) begin
            count_d = '0;
            state_d = ST_LOAD;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      n_q     <= '0;
      j_q     <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      j_q     <= j_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  assign in_ready_o  = state_q == ST_LOAD;
  assign out_valid_o = valid_q;
  assign out_last_o  = last_q;
endmodule

// File: design/probability_column_normalizer_top.sv
`timescale 1ns / 1ps
// Loading stores up to 64 values; the last transaction starts normalization of N entries.
// Normalization: a missing-mass correction, a residual fill of zero entries
// (serial divider, one quotient bit per cycle), and a per-entry rescale.
// Output: entries are registered and held until taken; throughput is one column at a time.
// Reset is asynchronous, active low: control and config registers reset, the column
// store is not cleared.
module probability_column_normalizer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pcn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pcn_pkg::CfgW-1:0]    cfg_data_i,
  pcn_in_if.sink                      in_i,
  pcn_out_if.source                   out_o
);
  pcn_pkg::dp_cmd_t    cmd;
  pcn_pkg::dp_status_t status;

  pcn_controller u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_element),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_o.last_out),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcn_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .value_in_i     (in_i.value_in),
    .loop_index_i   (in_i.loop_index),
    .added_sum_i    (in_i.added_sum),
    .virtual_used_i (in_i.virtual_used),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_out_o    (out_o.value_out)
  );
endmodule

// File: design/pcn_checker.sv
`timescale 1ns / 1ps
module pcn_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [pcn_pkg::ValueW-1:0] out_value_i,
  input logic                       out_last_i
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("input open while results pending");
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i) else $error("input open after last");
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("output valid dropped");
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_value_i) && $stable(out_last_i)))
    else $error("output payload changed while stalled");
endmodule

bind probability_column_normalizer_top pcn_checker u_pcn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_element),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value_out),
  .out_last_i  (out_o.last_out)
);

// File: bench/probability_column_normalizer_top_tb.sv
`timescale 1ns / 1ps
module probability_column_normalizer_top_tb;

  typedef struct {
    logic [pcn_pkg::ValueW-1:0] value;
    logic [pcn_pkg::IndexW-1:0] index;
    logic [pcn_pkg::SumW-1:0]   added;
    logic                       virt;
    logic                       last;
  } column_item_t;

  typedef struct {
    logic [pcn_pkg::ValueW-1:0] value;
    logic                       last;
  } norm_entry_t;

  class column_scoreboard;
    norm_entry_t                expected_q[$];
    logic [pcn_pkg::ValueW-1:0] store[pcn_pkg::ColumnDepth];
    int unsigned                count;
    logic [pcn_pkg::IndexW-1:0] held_index;
    logic [pcn_pkg::SumW-1:0]   held_sum;
    logic                       held_virtual;
    logic [15:0]                virt_prob;
    logic [19:0]                total_prob;
    logic [15:0]                min_prob;
    int unsigned                errors;

    function void clear();
      count = 0;
      held_index = '0;
      held_sum = '0;
      held_virtual = 1'b0;
      virt_prob = '0;
      total_prob = 20'(pcn_pkg::TotalReset);
      min_prob = '0;
      errors = 0;
    endfunction

    function void write_reg(pcn_pkg::cfg_index_e idx, logic [pcn_pkg::CfgW-1:0] data);
      case (idx)
        pcn_pkg::CFG_VIRTUAL: virt_prob = data[15:0];
        pcn_pkg::CFG_TOTAL:   total_prob = data;
        pcn_pkg::CFG_MIN:     min_prob = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] sat(longint v);
      return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function void normalize(int unsigned n);
      longint s, base, delta, max_norm, scaled;
      int unsigned first, fill;
      norm_entry_t e;
      s = held_sum;
      first = held_virtual ? 1 : 0;
      base = longint'(total_prob) - longint'(virt_prob);
      if (s < base) begin
        delta = base - s;
        if (held_index < n) begin
          store[held_index] = sat(longint'(store[held_index]) + delta);
          s += delta;
        end
      end
      if (total_prob < pcn_pkg::OneQ15 && n > 1) begin
        fill = (pcn_pkg::OneQ15 - total_prob) / (n - 1);
        for (int unsigned j = first; j < n; j++) begin
          if (store[j] == 0) begin
            store[j] = 16'(fill);
            s += fill;
          end
        end
      end
      max_norm = longint'(pcn_pkg::OneQ15) - (held_virtual ? longint'(virt_prob) : 0);
      if (max_norm < 0) max_norm = 0;
      if (s < max_norm - pcn_pkg::NormTol || s > max_norm + pcn_pkg::NormTol) begin
        for (int unsigned j = first; j < n; j++) begin
          scaled = (s > 0) ? (longint'(store[j]) * max_norm) / s : 0;
          store[j] = sat(scaled);
          if (store[j] < min_prob) store[j] = '0;
        end
      end
      if (held_virtual) store[0] = virt_prob;
      for (int unsigned j = 0; j < n; j++) begin
        e.value = store[j];
        e.last = (j + 1 == n);
        expected_q.insert(expected_q.size(), e);
      end
    endfunction

    function void note_input(column_item_t it);
      if (count == 0) begin
        held_index = it.index;
        held_sum = it.added;
        held_virtual = it.virt;
      end
      if (count < pcn_pkg::ColumnDepth) begin
        store[count] = it.value;
        count++;
      end
      if (it.last) begin
        normalize(count);
        count = 0;
      end
    endfunction

    function void check_result(logic [pcn_pkg::ValueW-1:0] value, logic last);
      norm_entry_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: value_out %0d last_out %0d", value, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (value !== e.value) begin
        $error("value_out: expected %0d, actual %0d", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_out: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 40000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  pcn_pkg::cfg_index_e cfg_index_i;
  logic [pcn_pkg::CfgW-1:0] cfg_data_i;

  pcn_in_if  in_ch ();
  pcn_out_if out_ch ();

  probability_column_normalizer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #4 clk_i = ~clk_i;

  column_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int idle_cycles;
  int items_sent;

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 700;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.value_out, out_ch.last_out);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(pcn_pkg::cfg_index_e idx, logic [pcn_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [15:0] vp, logic [19:0] tp, logic [15:0] mp);
    write_reg(pcn_pkg::CFG_VIRTUAL, pcn_pkg::CfgW'(vp));
    write_reg(pcn_pkg::CFG_TOTAL, tp);
    write_reg(pcn_pkg::CFG_MIN, pcn_pkg::CfgW'(mp));
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_item(column_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value_in <= it.value;
    in_ch.loop_index <= it.index;
    in_ch.added_sum <= it.added;
    in_ch.virtual_used <= it.virt;
    in_ch.last_element <= it.last;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(4))
      0: return '0;
      1: return 16'($urandom_range(1, 64));
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, 8192));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_column(int len, int val_mode);
    column_item_t it;
    int in_range;
    in_range = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      case (val_mode)
        1: it.value = '0;
        2: it.value = 16'hFFFF;
        default: it.value = rand_value();
      endcase
      it.index = in_range ? 6'($urandom_range(len > 64 ? 63 : len - 1)) : 6'($urandom);
      case ($urandom_range(3))
        0: it.added = '0;
        1: it.added = 20'hFFFFF;
        2: it.added = 20'($urandom_range(0, 40000));
        default: it.added = 20'($urandom);
      endcase
      it.virt = $urandom_range(1);
      it.last = (i == len - 1);
      send_item(it);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 96) return $urandom_range(9, 24);
    return 64;
  endfunction

  task automatic random_phase(int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) send_column(rand_len(), 0);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = pcn_pkg::CFG_VIRTUAL;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.value_in = '0;
    in_ch.loop_index = '0;
    in_ch.added_sum = '0;
    in_ch.virtual_used = 1'b0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    idle_cycles = 0;
    items_sent = 0;
    send_idle_pct = 19;
    recv_idle_pct = 62;
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset config: single entry, zeros, saturated entries, possibly out-of-range index
    send_column(1, 2);
    send_column(2, 1);
    send_column(3, 2);
    send_column(4, 0);
    drain();
    // zero entries with no fill, virtual at one, large floor
    configure(16'd32768, 20'd32768, 16'd32768);
    send_column(3, 1);
    send_column(5, 0);
    drain();
    // residual fill with total zero; column overflow
    configure(16'd0, 20'd0, 16'd0);
    send_column(3, 1);
    send_column(66, 0);
    drain();

    configure(16'($urandom_range(0, 8000)), 20'($urandom_range(0, 32767)),
              16'($urandom_range(0, 200)));
    random_phase(80);
    send_idle_pct = 62;
    recv_idle_pct = 19;
    configure(16'($urandom_range(0, 32768)), 20'hFFFFF, 16'($urandom_range(0, 3000)));
    hold_req <= hold_req + 1;
    random_phase(80);
    configure(16'($urandom_range(0, 4000)), 20'($urandom_range(30000, 36000)), 16'd0);
    random_phase(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'($urandom), 20'($urandom), 16'($urandom_range(0, 32768)));
    random_phase(70);
    configure(16'd0, 20'd32768, 16'd0);
    random_phase(70);

    drain();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// File: files.f
design/pcn_pkg.sv
design/pcn_in_if.sv
design/pcn_out_if.sv
design/pcn_ram.sv
design/pcn_divider.sv
design/pcn_datapath.sv
design/pcn_controller.sv
design/probability_column_normalizer_top.sv
design/pcn_checker.sv
bench/probability_column_normalizer_top_tb.sv
